FILE: design/uvs_pkg.sv
// Shared constants, field widths and the rounding helper for the UV sphere core.
// Has no dependencies; every design file imports it.
package uvs_pkg;

    localparam logic MODE_VERTEX   = 1'b0;
    localparam logic MODE_TRIANGLE = 1'b1;

    localparam int IDX_W    = 7;
    localparam int RADIUS_W = 16;
    localparam int POS_W    = 17;
    localparam int NORM_W   = 16;
    localparam int TEX_W    = 15;
    localparam int CORNER_W = 7;

    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 16'd256;
    localparam int                  ONE_Q14      = 16384;
    localparam logic [63:0]         PI_Q30       = 64'd3373259426;

    localparam logic [63:0] TAYLOR_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    // Drops 14 fraction bits, rounding to nearest with ties away from zero.
    function automatic logic signed [19:0] round_q14(input logic signed [33:0] v);
        logic signed [33:0] biased;
        biased = v + (v[33] ? 34'sd8191 : 34'sd8192);
        return 20'(biased >>> 14);
    endfunction

endpackage

FILE: design/uv_sphere_mesh_generator_core.sv
// UV sphere mesh element generator: one vertex or triangle word per request.
// done marks each word as it leaves the last stage; one word can start in every cycle.
// The six stages are: input capture, table lookup, sine-cosine multiply, round,
// radius multiply, round to output. busy is always low as the receiver cannot stall.
// Reset clears the stage valid bits and loads the radius with 1.0 (Q8.8).
// Depends on uvs_pkg for widths, constants and rounding.
module uv_sphere_mesh_generator_core #(
    parameter int SEGMENTS = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                mode,
    input  logic [uvs_pkg::IDX_W-1:0]           item_index,
    input  logic                                cfg_we,
    input  logic [uvs_pkg::RADIUS_W-1:0]        cfg_wdata,
    output logic                                done,
    output logic signed [uvs_pkg::POS_W-1:0]    pos_x,
    output logic signed [uvs_pkg::POS_W-1:0]    pos_y,
    output logic signed [uvs_pkg::POS_W-1:0]    pos_z,
    output logic signed [uvs_pkg::NORM_W-1:0]   norm_x,
    output logic signed [uvs_pkg::NORM_W-1:0]   norm_y,
    output logic signed [uvs_pkg::NORM_W-1:0]   norm_z,
    output logic [uvs_pkg::TEX_W-1:0]           tex_s,
    output logic [uvs_pkg::TEX_W-1:0]           tex_t,
    output logic [uvs_pkg::CORNER_W-1:0]        corner_a,
    output logic [uvs_pkg::CORNER_W-1:0]        corner_b,
    output logic [uvs_pkg::CORNER_W-1:0]        corner_c,
    output logic                                bad_index
);
    import uvs_pkg::*;

    localparam int SEGS     = (SEGMENTS < 2) ? 2 : SEGMENTS;
    localparam int COLS_H   = 2 * SEGS;
    localparam int RING_W   = COLS_H + 1;
    localparam int NV       = 2 + (SEGS - 1) * RING_W;
    localparam int NT       = 2 * COLS_H * (SEGS - 1);
    localparam int MID      = 2 * COLS_H * (SEGS - 2);
    localparam int TRI_ROW  = 2 * COLS_H;
    localparam int SIN_D    = 2 * SEGS;
    localparam int SIN_WRAP = 2 * SIN_D;
    localparam int HALF_D   = SIN_D / 2;
    localparam int HALF_S   = SEGS / 2;
    localparam int RING_N   = SEGS + 1;
    localparam int COL_N    = COLS_H + 1;
    localparam int RING_B   = $clog2(RING_N);
    localparam int COL_B    = $clog2(COL_N);
    localparam int IDX_N    = 2 ** IDX_W;

    typedef struct packed {
        logic              bad;
        logic [RING_B-1:0] ring;
        logic [COL_B-1:0]  col;
    } vtx_info_t;

    typedef struct packed {
        logic                bad;
        logic [CORNER_W-1:0] a;
        logic [CORNER_W-1:0] b;
        logic [CORNER_W-1:0] c;
    } tri_info_t;

    typedef struct packed {
        logic signed [NORM_W-1:0] sin_v;
        logic signed [NORM_W-1:0] cos_v;
        logic [TEX_W-1:0]         tex;
    } angle_info_t;

    typedef vtx_info_t   [IDX_N-1:0]  vtx_tab_t;
    typedef tri_info_t   [IDX_N-1:0]  tri_tab_t;
    typedef angle_info_t [RING_N-1:0] ring_tab_t;
    typedef angle_info_t [COL_N-1:0]  col_tab_t;

    // Sine in Q1.14 of k steps of pi/SIN_D, from a Q30 Taylor series.
    function automatic logic signed [NORM_W-1:0] sin_q14(input int unsigned k_in);
        logic [63:0]        k;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic signed [63:0] sum;
        logic               neg;
        k   = 64'(k_in % SIN_WRAP);
        neg = (k >= 64'(SIN_D));
        if (neg)
        begin
            k = k - 64'(SIN_D);
        end
        if (2 * k > 64'(SIN_D))
        begin
            k = 64'(SIN_D) - k;
        end
        x    = (k * PI_Q30 + 64'(HALF_D)) / SIN_D;
        x2   = (x * x) >> 30;
        term = x;
        sum  = $signed(x);
        for (int n = 1; n <= 8; n++)
        begin
            term = ((term * x2) >> 30) / TAYLOR_DIV[n - 1];
            if (n % 2 == 1)
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        if (sum < 0)
        begin
            sum = 0;
        end
        sum = (sum + 64'sd32768) >>> 16;
        if (sum > ONE_Q14)
        begin
            sum = ONE_Q14;
        end
        return NORM_W'(neg ? -sum : sum);
    endfunction

    // Poles map to the outer rings with the middle column, where sine is zero.
    function automatic vtx_tab_t build_vtx_tab();
        vtx_tab_t t;
        for (int i = 0; i < IDX_N; i++)
        begin
            t[i] = '0;
            if (i >= NV)
            begin
                t[i].bad = 1'b1;
            end
            else if (i == 0)
            begin
                t[i].col = COL_B'(SEGS);
            end
            else if (i == NV - 1)
            begin
                t[i].ring = RING_B'(SEGS);
                t[i].col  = COL_B'(SEGS);
            end
            else
            begin
                t[i].ring = RING_B'((i - 1) / RING_W + 1);
                t[i].col  = COL_B'((i - 1) % RING_W);
            end
        end
        return t;
    endfunction

    function automatic tri_tab_t build_tri_tab();
        tri_tab_t t;
        int m;
        int j;
        int r;
        int i0;
        int k;
        for (int i = 0; i < IDX_N; i++)
        begin
            t[i] = '0;
            if (i >= NT)
            begin
                t[i].bad = 1'b1;
            end
            else if (i < COLS_H)
            begin
                t[i].b = CORNER_W'(1 + i);
                t[i].c = CORNER_W'(2 + i);
            end
            else if (i < COLS_H + MID)
            begin
                m  = i - COLS_H;
                j  = m / TRI_ROW;
                r  = m % TRI_ROW;
                i0 = 1 + j * RING_W + r / 2;
                if (r % 2 == 0)
                begin
                    t[i].a = CORNER_W'(i0);
                    t[i].b = CORNER_W'(i0 + RING_W);
                    t[i].c = CORNER_W'(i0 + 1);
                end
                else
                begin
                    t[i].a = CORNER_W'(i0 + 1);
                    t[i].b = CORNER_W'(i0 + RING_W);
                    t[i].c = CORNER_W'(i0 + RING_W + 1);
                end
            end
            else
            begin
                k      = i - COLS_H - MID;
                t[i].a = CORNER_W'(NV - 1);
                t[i].b = CORNER_W'(NV - 2 - k);
                t[i].c = CORNER_W'(NV - 3 - k);
            end
        end
        return t;
    endfunction

    function automatic ring_tab_t build_ring_tab();
        ring_tab_t t;
        for (int r = 0; r < RING_N; r++)
        begin
            t[r].sin_v = sin_q14(2 * r);
            t[r].cos_v = sin_q14(2 * r + SEGS);
            t[r].tex   = TEX_W'(((SEGS - r) * ONE_Q14 + HALF_S) / SEGS);
        end
        return t;
    endfunction

    function automatic col_tab_t build_col_tab();
        col_tab_t t;
        for (int c = 0; c < COL_N; c++)
        begin
            t[c].sin_v = sin_q14(2 * c);
            t[c].cos_v = sin_q14(2 * c + SEGS);
            t[c].tex   = TEX_W'((c * ONE_Q14 + SEGS) / COLS_H);
        end
        return t;
    endfunction

    localparam vtx_tab_t  VTX_TAB  = build_vtx_tab();
    localparam tri_tab_t  TRI_TAB  = build_tri_tab();
    localparam ring_tab_t RING_TAB = build_ring_tab();
    localparam col_tab_t  COL_TAB  = build_col_tab();

    logic [RADIUS_W-1:0] radius_reg;

    logic                v1_reg;
    logic                mode1_reg;
    logic [IDX_W-1:0]    idx1_reg;

    logic                     v2_reg;
    logic                     bad2_reg;
    logic signed [NORM_W-1:0] sin_th2_reg;
    logic signed [NORM_W-1:0] cos_th2_reg;
    logic signed [NORM_W-1:0] sin_ph2_reg;
    logic signed [NORM_W-1:0] cos_ph2_reg;
    logic [TEX_W-1:0]         tex_s2_reg;
    logic [TEX_W-1:0]         tex_t2_reg;
    tri_info_t                tri2_reg;

    logic                     v3_reg;
    logic                     bad3_reg;
    logic signed [31:0]       prod_x3_reg;
    logic signed [31:0]       prod_y3_reg;
    logic signed [NORM_W-1:0] nz3_reg;
    logic [TEX_W-1:0]         tex_s3_reg;
    logic [TEX_W-1:0]         tex_t3_reg;
    tri_info_t                tri3_reg;

    logic                     v4_reg;
    logic                     bad4_reg;
    logic signed [NORM_W-1:0] nx4_reg;
    logic signed [NORM_W-1:0] ny4_reg;
    logic signed [NORM_W-1:0] nz4_reg;
    logic [TEX_W-1:0]         tex_s4_reg;
    logic [TEX_W-1:0]         tex_t4_reg;
    tri_info_t                tri4_reg;

    logic                     v5_reg;
    logic                     bad5_reg;
    logic signed [32:0]       prod_x5_reg;
    logic signed [32:0]       prod_y5_reg;
    logic signed [32:0]       prod_z5_reg;
    logic signed [NORM_W-1:0] nx5_reg;
    logic signed [NORM_W-1:0] ny5_reg;
    logic signed [NORM_W-1:0] nz5_reg;
    logic [TEX_W-1:0]         tex_s5_reg;
    logic [TEX_W-1:0]         tex_t5_reg;
    tri_info_t                tri5_reg;

    logic                     done_reg;
    logic signed [POS_W-1:0]  pos_x_reg;
    logic signed [POS_W-1:0]  pos_y_reg;
    logic signed [POS_W-1:0]  pos_z_reg;
    logic signed [NORM_W-1:0] norm_x_reg;
    logic signed [NORM_W-1:0] norm_y_reg;
    logic signed [NORM_W-1:0] norm_z_reg;
    logic [TEX_W-1:0]         tex_s_reg;
    logic [TEX_W-1:0]         tex_t_reg;
    tri_info_t                tri_out_reg;
    logic                     bad_out_reg;

    vtx_info_t                vtx_info;
    tri_info_t                tri_info;
    angle_info_t              ring_info;
    angle_info_t              col_info;
    logic                     vert_ok;
    logic                     bad2_next;
    logic signed [NORM_W-1:0] sin_th2_next;
    logic signed [NORM_W-1:0] cos_th2_next;
    logic signed [NORM_W-1:0] sin_ph2_next;
    logic signed [NORM_W-1:0] cos_ph2_next;
    logic [TEX_W-1:0]         tex_s2_next;
    logic [TEX_W-1:0]         tex_t2_next;
    tri_info_t                tri2_next;
    logic signed [RADIUS_W:0] radius_s;

    assign busy     = 1'b0;
    assign radius_s = $signed({1'b0, radius_reg});

    always_comb
    begin
        vtx_info  = VTX_TAB[idx1_reg];
        tri_info  = TRI_TAB[idx1_reg];
        ring_info = RING_TAB[vtx_info.ring];
        col_info  = COL_TAB[vtx_info.col];
        vert_ok   = (mode1_reg == MODE_VERTEX) && !vtx_info.bad;
        bad2_next = (mode1_reg == MODE_VERTEX) ? vtx_info.bad : tri_info.bad;
        tri2_next = (mode1_reg == MODE_TRIANGLE) ? tri_info : '0;
        tri2_next.bad = 1'b0;
        sin_th2_next = vert_ok ? ring_info.sin_v : '0;
        cos_th2_next = vert_ok ? ring_info.cos_v : '0;
        tex_t2_next  = vert_ok ? ring_info.tex : '0;
        sin_ph2_next = vert_ok ? col_info.sin_v : '0;
        cos_ph2_next = vert_ok ? col_info.cos_v : '0;
        tex_s2_next  = vert_ok ? col_info.tex : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg <= RADIUS_RESET;
            v1_reg     <= 1'b0;
            v2_reg     <= 1'b0;
            v3_reg     <= 1'b0;
            v4_reg     <= 1'b0;
            v5_reg     <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                radius_reg <= cfg_wdata;
            end
            v1_reg   <= start && !busy;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            v4_reg   <= v3_reg;
            v5_reg   <= v4_reg;
            done_reg <= v5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        mode1_reg <= mode;
        idx1_reg  <= item_index;

        bad2_reg    <= bad2_next;
        sin_th2_reg <= sin_th2_next;
        cos_th2_reg <= cos_th2_next;
        sin_ph2_reg <= sin_ph2_next;
        cos_ph2_reg <= cos_ph2_next;
        tex_s2_reg  <= tex_s2_next;
        tex_t2_reg  <= tex_t2_next;
        tri2_reg    <= tri2_next;

        bad3_reg    <= bad2_reg;
        prod_x3_reg <= sin_th2_reg * cos_ph2_reg;
        prod_y3_reg <= sin_th2_reg * sin_ph2_reg;
        nz3_reg     <= cos_th2_reg;
        tex_s3_reg  <= tex_s2_reg;
        tex_t3_reg  <= tex_t2_reg;
        tri3_reg    <= tri2_reg;

        bad4_reg   <= bad3_reg;
        nx4_reg    <= NORM_W'(round_q14(34'(prod_x3_reg)));
        ny4_reg    <= NORM_W'(round_q14(34'(prod_y3_reg)));
        nz4_reg    <= nz3_reg;
        tex_s4_reg <= tex_s3_reg;
        tex_t4_reg <= tex_t3_reg;
        tri4_reg   <= tri3_reg;

        bad5_reg    <= bad4_reg;
        prod_x5_reg <= radius_s * nx4_reg;
        prod_y5_reg <= radius_s * ny4_reg;
        prod_z5_reg <= radius_s * nz4_reg;
        nx5_reg     <= nx4_reg;
        ny5_reg     <= ny4_reg;
        nz5_reg     <= nz4_reg;
        tex_s5_reg  <= tex_s4_reg;
        tex_t5_reg  <= tex_t4_reg;
        tri5_reg    <= tri4_reg;

        bad_out_reg <= bad5_reg;
        pos_x_reg   <= POS_W'(round_q14(34'(prod_x5_reg)));
        pos_y_reg   <= POS_W'(round_q14(34'(prod_y5_reg)));
        pos_z_reg   <= POS_W'(round_q14(34'(prod_z5_reg)));
        norm_x_reg  <= nx5_reg;
        norm_y_reg  <= ny5_reg;
        norm_z_reg  <= nz5_reg;
        tex_s_reg   <= tex_s5_reg;
        tex_t_reg   <= tex_t5_reg;
        tri_out_reg <= tri5_reg;
    end

    assign done      = done_reg;
    assign pos_x     = pos_x_reg;
    assign pos_y     = pos_y_reg;
    assign pos_z     = pos_z_reg;
    assign norm_x    = norm_x_reg;
    assign norm_y    = norm_y_reg;
    assign norm_z    = norm_z_reg;
    assign tex_s     = tex_s_reg;
    assign tex_t     = tex_t_reg;
    assign corner_a  = tri_out_reg.a;
    assign corner_b  = tri_out_reg.b;
    assign corner_c  = tri_out_reg.c;
    assign bad_index = bad_out_reg;

    // Every accepted request produces its word, marked by done, at the end of the pipeline.
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##6 done)
        else $error("accepted request produced no result word");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && bad_index) |-> (pos_x == 0 && pos_y == 0 && pos_z == 0 &&
            norm_x == 0 && norm_y == 0 && norm_z == 0 && tex_s == 0 && tex_t == 0 &&
            corner_a == 0 && corner_b == 0 && corner_c == 0))
        else $error("out-of-range word carries nonzero fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && (corner_b != 0 || corner_c != 0)) |-> (pos_x == 0 && pos_y == 0 &&
            pos_z == 0 && norm_x == 0 && norm_y == 0 && norm_z == 0 &&
            tex_s == 0 && tex_t == 0))
        else $error("triangle word carries vertex fields");

    assert property (@(posedge clk) disable iff (!rst_n)
        (done && norm_x == 0 && norm_y == 0 && norm_z == 0) |->
            (pos_x == 0 && pos_y == 0 && pos_z == 0))
        else $error("zero normal gave a nonzero position");

endmodule
